/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (a) |-> (c)) \
    else $error("implication check failed");
`define ASSERT_NEVER(lbl, ck, rs, a) \
  lbl: assert property (@(posedge ck) disable iff (!rs) !(a)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPLIES(lbl, ck, rs, a, c)
`define ASSERT_NEVER(lbl, ck, rs, a)
`endif
`endif

/* rtl/asb_pkg.sv */
// Shared types and constants for the antialiased shape pixel blend.
`default_nettype none
package asb_pkg;

  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 3;
  localparam int RGB_BITS       = 24;
  localparam int CH_BITS        = 8;

  localparam int D_LIMIT      = 512;
  localparam int U_BITS       = 10;
  localparam int U2_BITS      = 20;
  localparam int W_BITS       = 11;
  localparam int NUM_BITS     = 28;
  localparam int NUM_TOP      = 27;
  localparam int CUBIC_BASE   = 1536;
  localparam int RADIUS_SHIFT = 8;
  localparam int DIST_SHIFT   = 16;
  localparam int QUO_BITS     = 18;
  localparam int GEOM_STAGES  = 6;
  localparam int BLEND_STAGES = 5;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SHAPE_MODE    = 3'd0,
    CFG_POINT_A_X     = 3'd1,
    CFG_POINT_A_Y     = 3'd2,
    CFG_POINT_B_X     = 3'd3,
    CFG_POINT_B_Y     = 3'd4,
    CFG_CIRCLE_RADIUS = 3'd5,
    CFG_DRAW_COLOR    = 3'd6
  } asb_cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_LINE    = 2'd0,
    MODE_OUTLINE = 2'd1,
    MODE_FILLED  = 2'd2
  } asb_mode_t;

  typedef struct packed {
    logic use_q;
    logic far;
    logic blank;
  } asb_flags_t;

endpackage
`default_nettype wire

/* rtl/asb_geom.sv */
// Geometry front end: differences, products, projection tests and cross product square.
`default_nettype none
module asb_geom
  import asb_pkg::*;
#(
  parameter int CW = 12
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [CW-1:0]     px,
  input  wire logic [CW-1:0]     py,
  input  wire logic [RGB_BITS-1:0] in_rgb,
  input  wire logic [1:0]        mode,
  input  wire logic [CW-1:0]     ax,
  input  wire logic [CW-1:0]     ay,
  input  wire logic [CW-1:0]     bx,
  input  wire logic [CW-1:0]     by,
  output logic                   out_valid,
  output logic [2*CW:0]          out_rem,
  output logic [1:0]             out_lo,
  output logic [2*CW:0]          out_len,
  output logic [2*CW:0]          out_e,
  output asb_flags_t             out_flags,
  output logic [RGB_BITS-1:0]    out_rgb
);

  localparam int DW  = 2*CW+1;
  localparam int PW  = 2*CW+2;
  localparam int SW3 = 2*CW+3;

  // stage 1
  logic              v1_r;
  logic signed [CW:0] acx_r, acy_r, abx_r, aby_r, bcx_r, bcy_r;
  logic signed [CW:0] acx_nxt, acy_nxt, abx_nxt, aby_nxt, bcx_nxt, bcy_nxt;
  logic [RGB_BITS-1:0] rgb1_r;

  assign acx_nxt = $signed({1'b0, px}) - $signed({1'b0, ax});
  assign acy_nxt = $signed({1'b0, py}) - $signed({1'b0, ay});
  assign abx_nxt = $signed({1'b0, bx}) - $signed({1'b0, ax});
  assign aby_nxt = $signed({1'b0, by}) - $signed({1'b0, ay});
  assign bcx_nxt = $signed({1'b0, px}) - $signed({1'b0, bx});
  assign bcy_nxt = $signed({1'b0, py}) - $signed({1'b0, by});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    acx_r  <= acx_nxt;
    acy_r  <= acy_nxt;
    abx_r  <= abx_nxt;
    aby_r  <= aby_nxt;
    bcx_r  <= bcx_nxt;
    bcy_r  <= bcy_nxt;
    rgb1_r <= in_rgb;
  end

  // stage 2
  logic                 v2_r;
  logic signed [PW-1:0] pdx_r, pdy_r, pca_r, pcb_r, pabx_r, paby_r;
  logic signed [PW-1:0] peax_r, peay_r, pebx_r, peby_r;
  logic [RGB_BITS-1:0]  rgb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    pdx_r  <= acx_r * abx_r;
    pdy_r  <= acy_r * aby_r;
    pca_r  <= acx_r * aby_r;
    pcb_r  <= acy_r * abx_r;
    pabx_r <= abx_r * abx_r;
    paby_r <= aby_r * aby_r;
    peax_r <= acx_r * acx_r;
    peay_r <= acy_r * acy_r;
    pebx_r <= bcx_r * bcx_r;
    peby_r <= bcy_r * bcy_r;
    rgb2_r <= rgb1_r;
  end

  // stage 3
  logic                  v3_r;
  logic signed [SW3-1:0] dot_r, cross_r;
  logic [DW-1:0]         len3_r, ea3_r, eb3_r;
  logic [RGB_BITS-1:0]   rgb3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dot_r   <= $signed({pdx_r[PW-1], pdx_r}) + $signed({pdy_r[PW-1], pdy_r});
    cross_r <= $signed({pca_r[PW-1], pca_r}) - $signed({pcb_r[PW-1], pcb_r});
    len3_r  <= pabx_r[DW-1:0] + paby_r[DW-1:0];
    ea3_r   <= peax_r[DW-1:0] + peay_r[DW-1:0];
    eb3_r   <= pebx_r[DW-1:0] + peby_r[DW-1:0];
    rgb3_r  <= rgb2_r;
  end

  // stage 4
  logic                  v4_r;
  logic                  near_a, beyond, is_line, mode_ok;
  logic signed [SW3-1:0] cr_abs;
  logic [DW-1:0]         cr4_r, len4_r, e4_r, e4_nxt;
  asb_flags_t            fl4_r, fl4_nxt;
  logic [RGB_BITS-1:0]   rgb4_r;

  always_comb begin
    is_line = (mode == MODE_LINE);
    mode_ok = (mode == MODE_LINE) || (mode == MODE_OUTLINE) || (mode == MODE_FILLED);
    near_a  = dot_r[SW3-1] || (dot_r == '0);
    beyond  = dot_r >= $signed({2'b00, len3_r});
    cr_abs  = cross_r[SW3-1] ? -cross_r : cross_r;
    e4_nxt  = (is_line && !near_a && beyond) ? eb3_r : ea3_r;
    fl4_nxt.use_q = is_line && !near_a && !beyond;
    fl4_nxt.far   = 1'b0;
    fl4_nxt.blank = !mode_ok || (is_line && (len3_r == '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    cr4_r  <= cr_abs[DW-1:0];
    len4_r <= len3_r;
    e4_r   <= e4_nxt;
    fl4_r  <= fl4_nxt;
    rgb4_r <= rgb3_r;
  end

  // stage 5
  logic                v5_r;
  logic [2*DW-1:0]     c5_r;
  logic [DW-1:0]       len5_r, e5_r;
  asb_flags_t          fl5_r;
  logic [RGB_BITS-1:0] rgb5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    c5_r   <= cr4_r * cr4_r;
    len5_r <= len4_r;
    e5_r   <= e4_r;
    fl5_r  <= fl4_r;
    rgb5_r <= rgb4_r;
  end

  // stage 6
  logic                v6_r;
  asb_flags_t          fl6_nxt;
  logic [DW-1:0]       rem6_r, len6_r, e6_r;
  logic [1:0]          lo6_r;
  asb_flags_t          fl6_r;
  logic [RGB_BITS-1:0] rgb6_r;

  always_comb begin
    fl6_nxt     = fl5_r;
    fl6_nxt.far = c5_r >= {{(DW-2){1'b0}}, len5_r, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    rem6_r <= c5_r[DW+1:2];
    lo6_r  <= c5_r[1:0];
    len6_r <= len5_r;
    e6_r   <= e5_r;
    fl6_r  <= fl6_nxt;
    rgb6_r <= rgb5_r;
  end

  assign out_valid = v6_r;
  assign out_rem   = rem6_r;
  assign out_lo    = lo6_r;
  assign out_len   = len6_r;
  assign out_e     = e6_r;
  assign out_flags = fl6_r;
  assign out_rgb   = rgb6_r;

endmodule
`default_nettype wire

/* rtl/asb_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module asb_div #(
  parameter int DW  = 25,
  parameter int QB  = 18,
  parameter int SBW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [DW-1:0]  in_rem,
  input  wire logic [QB-1:0]  in_lo,
  input  wire logic [DW-1:0]  in_den,
  input  wire logic [SBW-1:0] in_sb,
  output logic                out_valid,
  output logic [QB-1:0]       out_q,
  output logic [SBW-1:0]      out_sb
);

  logic           v_r   [QB];
  logic [DW-1:0]  rem_r [QB];
  logic [QB-1:0]  lo_r  [QB];
  logic [QB-1:0]  q_r   [QB];
  logic [DW-1:0]  den_r [QB];
  logic [SBW-1:0] sb_r  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic           v_i;
    logic [DW-1:0]  rem_i, den_i, rem_nxt;
    logic [QB-1:0]  lo_i, q_i, lo_nxt, q_nxt;
    logic [SBW-1:0] sb_i;
    logic [DW:0]    trial, diff;
    logic           ge;

    if (k == 0) begin : g_head
      assign v_i   = in_valid;
      assign rem_i = in_rem;
      assign lo_i  = in_lo;
      assign q_i   = '0;
      assign den_i = in_den;
      assign sb_i  = in_sb;
    end else begin : g_body
      assign v_i   = v_r[k-1];
      assign rem_i = rem_r[k-1];
      assign lo_i  = lo_r[k-1];
      assign q_i   = q_r[k-1];
      assign den_i = den_r[k-1];
      assign sb_i  = sb_r[k-1];
    end

    assign trial   = {rem_i, lo_i[QB-1]};
    assign diff    = trial - {1'b0, den_i};
    assign ge      = trial >= {1'b0, den_i};
    assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign lo_nxt  = {lo_i[QB-2:0], 1'b0};
    assign q_nxt   = {q_i[QB-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      lo_r[k]  <= lo_nxt;
      q_r[k]   <= q_nxt;
      den_r[k] <= den_i;
      sb_r[k]  <= sb_i;
    end
  end

  assign out_valid = v_r[QB-1];
  assign out_q     = q_r[QB-1];
  assign out_sb    = sb_r[QB-1];

endmodule
`default_nettype wire

/* rtl/asb_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module asb_isqrt #(
  parameter int RW  = 21,
  parameter int SBW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [2*RW-1:0] in_opnd,
  input  wire logic [SBW-1:0]  in_sb,
  output logic                 out_valid,
  output logic [RW-1:0]        out_root,
  output logic [SBW-1:0]       out_sb
);

  logic            v_r    [RW];
  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] op_r   [RW];
  logic [SBW-1:0]  sb_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            v_i;
    logic [RW+1:0]   rem_i, rem_nxt;
    logic [RW-1:0]   root_i, root_nxt;
    logic [2*RW-1:0] op_i, op_nxt;
    logic [SBW-1:0]  sb_i;
    logic [RW+3:0]   trial, cmp, diff;
    logic            ge;

    if (k == 0) begin : g_head
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign op_i   = in_opnd;
      assign sb_i   = in_sb;
    end else begin : g_body
      assign v_i    = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign op_i   = op_r[k-1];
      assign sb_i   = sb_r[k-1];
    end

    assign trial    = {rem_i, op_i[2*RW-1:2*RW-2]};
    assign cmp      = {2'b00, root_i, 2'b01};
    assign diff     = trial - cmp;
    assign ge       = trial >= cmp;
    assign rem_nxt  = ge ? diff[RW+1:0] : trial[RW+1:0];
    assign root_nxt = {root_i[RW-2:0], ge};
    assign op_nxt   = {op_i[2*RW-3:0], 2'b00};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      op_r[k]   <= op_nxt;
      sb_r[k]   <= sb_i;
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_sb    = sb_r[RW-1];

endmodule
`default_nettype wire

/* rtl/asb_blend.sv */
// Distance to coverage, smoothstep alpha and colour blend.
`default_nettype none
module asb_blend
  import asb_pkg::*;
#(
  parameter int CW = 12,
  parameter int FB = 16,
  parameter int RW = 21
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [RW-1:0]       root,
  input  wire asb_flags_t          flags,
  input  wire logic [RGB_BITS-1:0] in_rgb,
  input  wire logic [1:0]          mode,
  input  wire logic [CW-1:0]       radius,
  input  wire logic [RGB_BITS-1:0] color,
  output logic                     out_valid,
  output logic [CH_BITS-1:0]       out_red,
  output logic [CH_BITS-1:0]       out_green,
  output logic [CH_BITS-1:0]       out_blue
);

  localparam int PB = FB + 1 + CH_BITS;

  // stage 1: distance and u
  logic                v1_r, cov;
  logic [RW-1:0]       rfix, d;
  logic [U_BITS-1:0]   u1_r, u_nxt;
  logic [RGB_BITS-1:0] rgb1_r;

  always_comb begin
    rfix = {{(RW-CW-RADIUS_SHIFT){1'b0}}, radius, {RADIUS_SHIFT{1'b0}}};
    d    = root;
    cov  = 1'b0;
    unique case (mode)
      MODE_LINE: begin
        d   = (flags.use_q && flags.far) ? RW'(D_LIMIT) : root;
        cov = 1'b1;
      end
      MODE_OUTLINE: begin
        d   = (root >= rfix) ? root - rfix : rfix - root;
        cov = 1'b1;
      end
      MODE_FILLED: begin
        d   = (root > rfix) ? root - rfix : '0;
        cov = 1'b1;
      end
      default: begin
        d   = root;
        cov = 1'b0;
      end
    endcase
    if (flags.blank || (d >= RW'(D_LIMIT))) begin
      cov = 1'b0;
    end
    u_nxt = cov ? (U_BITS'(D_LIMIT) - {1'b0, d[U_BITS-2:0]}) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    u1_r   <= u_nxt;
    rgb1_r <= in_rgb;
  end

  // stage 2: u squared and cubic weight
  logic                v2_r;
  logic [U2_BITS-1:0]  u2_r;
  logic [W_BITS-1:0]   w2_r;
  logic [RGB_BITS-1:0] rgb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    u2_r   <= u1_r * u1_r;
    w2_r   <= W_BITS'(CUBIC_BASE) - {u1_r, 1'b0};
    rgb2_r <= rgb1_r;
  end

  // stage 3: numerator
  logic                        v3_r;
  logic [U2_BITS+W_BITS-1:0]   num_full;
  logic [NUM_BITS-1:0]         num3_r;
  logic [RGB_BITS-1:0]         rgb3_r;

  assign num_full = u2_r * w2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    num3_r <= num_full[NUM_BITS-1:0];
    rgb3_r <= rgb2_r;
  end

  // stage 4: alpha and weighted channels
  logic               v4_r;
  logic [FB:0]        alpha, nalpha;
  logic [CH_BITS-1:0] old_ch [3];
  logic [CH_BITS-1:0] col_ch [3];
  logic [PB-1:0]      po_r   [3];
  logic [PB-1:0]      pc_r   [3];

  assign alpha  = num3_r[NUM_TOP -: FB+1];
  assign nalpha = {1'b1, {FB{1'b0}}} - alpha;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      old_ch[k] = rgb3_r[RGB_BITS-1-CH_BITS*k -: CH_BITS];
      col_ch[k] = color[RGB_BITS-1-CH_BITS*k -: CH_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      po_r[k] <= old_ch[k] * nalpha;
      pc_r[k] <= col_ch[k] * alpha;
    end
  end

  // stage 5: sum and truncate
  logic               v5_r;
  logic [PB:0]        sum [3];
  logic [CH_BITS-1:0] ch5_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = {1'b0, po_r[k]} + {1'b0, pc_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ch5_r[k] <= sum[k][FB+CH_BITS-1:FB];
    end
  end

  assign out_valid = v5_r;
  assign out_red   = ch5_r[0];
  assign out_green = ch5_r[1];
  assign out_blue  = ch5_r[2];

endmodule
`default_nettype wire

/* rtl/antialiased_shape_pixel_blend_top.sv */
// Top level of the antialiased shape pixel blend.
//
// Draws an antialiased line segment, circle outline or filled circle over a
// stream of pixels. Each beat on the input carries one pixel coordinate and
// its current colour; it is taken at a clock edge with start high and busy
// low. busy stays low: a new beat may be issued in every cycle.
// Each result beat appears on out_new_* for one cycle with out_valid high,
// after its input beat has passed 6 geometry stages, 18 divider stages,
// COORD_BITS + 9 square root stages and 5 blend stages.
// Results leave in input order at one per cycle.
// The receiver cannot stall; the pipeline always advances.
// Write shape registers through cfg_we/cfg_index/cfg_wdata only while no
// beat is in flight; an unknown index is ignored.
// Synchronous reset clears the registers and drops every beat in flight.
`default_nettype none
`include "assert_macros.svh"
module antialiased_shape_pixel_blend_top
  import asb_pkg::*;
#(
  parameter int COORD_BITS      = 12,
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [COORD_BITS-1:0]     in_pixel_x,
  input  wire logic [COORD_BITS-1:0]     in_pixel_y,
  input  wire logic [CH_BITS-1:0]        in_old_red,
  input  wire logic [CH_BITS-1:0]        in_old_green,
  input  wire logic [CH_BITS-1:0]        in_old_blue,
  output logic                           out_valid,
  output logic [CH_BITS-1:0]             out_new_red,
  output logic [CH_BITS-1:0]             out_new_green,
  output logic [CH_BITS-1:0]             out_new_blue,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int CW  = COORD_BITS;
  localparam int DW  = 2*CW+1;
  localparam int RW  = CW+9;
  localparam int FLB = $bits(asb_flags_t);
  localparam int SB1 = DW+FLB+RGB_BITS;
  localparam int SB2 = FLB+RGB_BITS;
  localparam int LAT = GEOM_STAGES+QUO_BITS+RW+BLEND_STAGES;

  logic [1:0]          mode_r;
  logic [CW-1:0]       ax_r, ay_r, bx_r, by_r, radius_r;
  logic [RGB_BITS-1:0] color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      ax_r     <= '0;
      ay_r     <= '0;
      bx_r     <= '0;
      by_r     <= '0;
      radius_r <= '0;
      color_r  <= '0;
    end else if (cfg_we) begin
      unique case (asb_cfg_idx_t'(cfg_index))
        CFG_SHAPE_MODE:    mode_r   <= cfg_wdata[1:0];
        CFG_POINT_A_X:     ax_r     <= cfg_wdata[CW-1:0];
        CFG_POINT_A_Y:     ay_r     <= cfg_wdata[CW-1:0];
        CFG_POINT_B_X:     bx_r     <= cfg_wdata[CW-1:0];
        CFG_POINT_B_Y:     by_r     <= cfg_wdata[CW-1:0];
        CFG_CIRCLE_RADIUS: radius_r <= cfg_wdata[CW-1:0];
        CFG_DRAW_COLOR:    color_r  <= cfg_wdata[RGB_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // geometry
  logic                gv;
  logic [DW-1:0]       g_rem, g_len, g_e;
  logic [1:0]          g_lo;
  asb_flags_t          g_flags;
  logic [RGB_BITS-1:0] g_rgb;

  asb_geom #(.CW(CW)) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .px        (in_pixel_x),
    .py        (in_pixel_y),
    .in_rgb    ({in_old_red, in_old_green, in_old_blue}),
    .mode      (mode_r),
    .ax        (ax_r),
    .ay        (ay_r),
    .bx        (bx_r),
    .by        (by_r),
    .out_valid (gv),
    .out_rem   (g_rem),
    .out_lo    (g_lo),
    .out_len   (g_len),
    .out_e     (g_e),
    .out_flags (g_flags),
    .out_rgb   (g_rgb)
  );

  // divider
  logic                dv;
  logic [QUO_BITS-1:0] d_q;
  logic [SB1-1:0]      d_sb;
  logic [DW-1:0]       d_e;
  asb_flags_t          d_flags;
  logic [RGB_BITS-1:0] d_rgb;

  asb_div #(.DW(DW), .QB(QUO_BITS), .SBW(SB1)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (gv),
    .in_rem    (g_rem),
    .in_lo     ({g_lo, {(QUO_BITS-2){1'b0}}}),
    .in_den    (g_len),
    .in_sb     ({g_e, g_flags, g_rgb}),
    .out_valid (dv),
    .out_q     (d_q),
    .out_sb    (d_sb)
  );

  assign {d_e, d_flags, d_rgb} = d_sb;

  // square root
  logic [2*RW-1:0]     s_opnd;
  logic                sv;
  logic [RW-1:0]       s_root;
  logic [SB2-1:0]      s_sb;
  asb_flags_t          s_flags;
  logic [RGB_BITS-1:0] s_rgb;

  assign s_opnd = d_flags.use_q ? {{(2*RW-QUO_BITS){1'b0}}, d_q}
                                : {{(2*RW-DW-DIST_SHIFT){1'b0}}, d_e, {DIST_SHIFT{1'b0}}};

  asb_isqrt #(.RW(RW), .SBW(SB2)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv),
    .in_opnd   (s_opnd),
    .in_sb     ({d_flags, d_rgb}),
    .out_valid (sv),
    .out_root  (s_root),
    .out_sb    (s_sb)
  );

  assign {s_flags, s_rgb} = s_sb;

  // blend
  asb_blend #(.CW(CW), .FB(ALPHA_FRAC_BITS), .RW(RW)) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sv),
    .root      (s_root),
    .flags     (s_flags),
    .in_rgb    (s_rgb),
    .mode      (mode_r),
    .radius    (radius_r),
    .color     (color_r),
    .out_valid (out_valid),
    .out_red   (out_new_red),
    .out_green (out_new_green),
    .out_blue  (out_new_blue)
  );

  `ASSERT_IMPLIES(a_out_latency, clk, rst_n, out_valid, $past(start, LAT))
  `ASSERT_IMPLIES(a_div_latency, clk, rst_n, dv, $past(gv, QUO_BITS))
  `ASSERT_IMPLIES(a_sqrt_latency, clk, rst_n, sv, $past(dv, RW))

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the antialiased shape pixel blend: directed and random pixel beats.
`timescale 1ns / 100ps
module tb_top;
  import asb_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int ALPHA_FRAC_BITS = 16;
  localparam int LATENCY = COORD_BITS + 38;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [COORD_BITS-1:0] in_pixel_x;
  logic [COORD_BITS-1:0] in_pixel_y;
  logic [7:0] in_old_red;
  logic [7:0] in_old_green;
  logic [7:0] in_old_blue;
  logic out_valid;
  logic [7:0] out_new_red;
  logic [7:0] out_new_green;
  logic [7:0] out_new_blue;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  logic [1:0] shape_mode_q;
  logic [11:0] ax_q, ay_q, bx_q, by_q, radius_q;
  logic [23:0] color_q;

  rgb_t blended_q[$];
  int fail_count;
  int mismatch_count;
  int beats_sent;
  int beats_checked;
  int gap_pct;

  antialiased_shape_pixel_blend_top #(
    .COORD_BITS(COORD_BITS),
    .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)
  ) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .in_old_red(in_old_red), .in_old_green(in_old_green), .in_old_blue(in_old_blue),
    .out_valid(out_valid), .out_new_red(out_new_red),
    .out_new_green(out_new_green), .out_new_blue(out_new_blue),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag64(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned span_fp(longint dx, longint dy);
    longint unsigned ux;
    longint unsigned uy;
    ux = mag64(dx);
    uy = mag64(dy);
    return root64((ux * ux + uy * uy) << 16);
  endfunction

  function automatic longint unsigned segment_dist(longint px, longint py, output bit ok);
    longint abx, aby, acx, acy, len2, dot;
    longint unsigned cr, c2;
    abx = longint'(bx_q) - longint'(ax_q);
    aby = longint'(by_q) - longint'(ay_q);
    acx = px - longint'(ax_q);
    acy = py - longint'(ay_q);
    len2 = abx * abx + aby * aby;
    ok = 1'b1;
    if (len2 == 0) begin
      ok = 1'b0;
      return 0;
    end
    dot = acx * abx + acy * aby;
    if (dot <= 0) return span_fp(acx, acy);
    if (dot >= len2) return span_fp(px - longint'(bx_q), py - longint'(by_q));
    cr = mag64(acx * aby - acy * abx);
    if (cr >= (64'd1 << 32)) return D_LIMIT;
    c2 = cr * cr;
    if (c2 >= 4 * longint'(len2)) return D_LIMIT;
    return root64((c2 << 16) / longint'(len2));
  endfunction

  function automatic rgb_t shade_pixel(logic [11:0] px, logic [11:0] py, rgb_t old);
    longint unsigned d, alpha, u, num, one, dc, r, col, ov;
    bit ok;
    rgb_t res;
    d = D_LIMIT;
    alpha = 0;
    ok = 1'b1;
    one = 64'd1 << ALPHA_FRAC_BITS;
    if (shape_mode_q == MODE_LINE) begin
      d = segment_dist(longint'(px), longint'(py), ok);
    end else if (shape_mode_q == MODE_OUTLINE || shape_mode_q == MODE_FILLED) begin
      dc = span_fp(longint'(px) - longint'(ax_q), longint'(py) - longint'(ay_q));
      r = longint'(radius_q) << 8;
      if (shape_mode_q == MODE_OUTLINE) d = (dc >= r) ? dc - r : r - dc;
      else d = (dc > r) ? dc - r : 0;
    end else begin
      ok = 1'b0;
    end
    if (ok && d < D_LIMIT) begin
      u = D_LIMIT - d;
      num = u * u * (1536 - 2 * u);
      alpha = (num << ALPHA_FRAC_BITS) >> 27;
    end
    res = old;
    if (alpha > 0) begin
      col = color_q[23:16];
      ov = old.red;
      res.red = 8'((ov * (one - alpha) + col * alpha) >> ALPHA_FRAC_BITS);
      col = color_q[15:8];
      ov = old.green;
      res.green = 8'((ov * (one - alpha) + col * alpha) >> ALPHA_FRAC_BITS);
      col = color_q[7:0];
      ov = old.blue;
      res.blue = 8'((ov * (one - alpha) + col * alpha) >> ALPHA_FRAC_BITS);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid) begin
      beats_checked <= beats_checked + 1;
      if (blended_q.size() == 0) begin
        fail_count = fail_count + 1;
        if (mismatch_count < 10) $display("unexpected result beat %h%h%h",
                                          out_new_red, out_new_green, out_new_blue);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = blended_q.pop_front();
        if (out_new_red !== want.red || out_new_green !== want.green ||
            out_new_blue !== want.blue) begin
          fail_count = fail_count + 1;
          if (mismatch_count < 10)
            $display("rgb mismatch: expected %h %h %h, got %h %h %h", want.red,
                     want.green, want.blue, out_new_red, out_new_green, out_new_blue);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  task automatic send_pixel(logic [11:0] px, logic [11:0] py, rgb_t old);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_pixel_x <= px;
    in_pixel_y <= py;
    in_old_red <= old.red;
    in_old_green <= old.green;
    in_old_blue <= old.blue;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    blended_q.insert(blended_q.size(), shade_pixel(px, py, old));
    beats_sent = beats_sent + 1;
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (blended_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(asb_cfg_idx_t idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_SHAPE_MODE: shape_mode_q = val[1:0];
      CFG_POINT_A_X: ax_q = val[11:0];
      CFG_POINT_A_Y: ay_q = val[11:0];
      CFG_POINT_B_X: bx_q = val[11:0];
      CFG_POINT_B_Y: by_q = val[11:0];
      CFG_CIRCLE_RADIUS: radius_q = val[11:0];
      CFG_DRAW_COLOR: color_q = val;
      default: ;
    endcase
  endtask

  task automatic set_shape(logic [1:0] mode, logic [11:0] pax, logic [11:0] pay,
                           logic [11:0] pbx, logic [11:0] pby, logic [11:0] rad,
                           logic [23:0] col);
    write_reg(CFG_SHAPE_MODE, {22'd0, mode});
    write_reg(CFG_POINT_A_X, {12'd0, pax});
    write_reg(CFG_POINT_A_Y, {12'd0, pay});
    write_reg(CFG_POINT_B_X, {12'd0, pbx});
    write_reg(CFG_POINT_B_Y, {12'd0, pby});
    write_reg(CFG_CIRCLE_RADIUS, {12'd0, rad});
    write_reg(CFG_DRAW_COLOR, col);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic rgb_t any_rgb();
    return rgb_t'(24'($urandom_range(24'hFFFFFF)));
  endfunction

  task automatic test_directed;
    set_shape(MODE_LINE, 12'd100, 12'd100, 12'd200, 12'd150, 12'd0, 24'hFF8000);
    send_pixel(12'd150, 12'd125, rgb_t'(24'h000000));
    send_pixel(12'd150, 12'd126, rgb_t'(24'hFFFFFF));
    send_pixel(12'd99, 12'd99, rgb_t'(24'h123456));
    send_pixel(12'd201, 12'd151, rgb_t'(24'hABCDEF));
    send_pixel(12'd150, 12'd140, rgb_t'(24'h808080));
    send_pixel(12'd4095, 12'd4095, rgb_t'(24'hFFFFFF));
    drain();
    set_shape(MODE_LINE, 12'd4095, 12'd0, 12'd0, 12'd4095, 12'd0, 24'hFFFFFF);
    send_pixel(12'd2048, 12'd2048, rgb_t'(24'h000000));
    send_pixel(12'd0, 12'd0, rgb_t'(24'h000000));
    send_pixel(12'd4095, 12'd4095, rgb_t'(24'h00FF00));
    drain();
    // zero-length line
    set_shape(MODE_LINE, 12'd50, 12'd50, 12'd50, 12'd50, 12'd4, 24'hFFFFFF);
    send_pixel(12'd50, 12'd50, rgb_t'(24'h010203));
    drain();
    set_shape(MODE_OUTLINE, 12'd2000, 12'd2000, 12'd0, 12'd0, 12'd10, 24'h00FF7F);
    send_pixel(12'd2010, 12'd2000, rgb_t'(24'h000000));
    send_pixel(12'd2000, 12'd2000, rgb_t'(24'hFFFFFF));
    send_pixel(12'd2011, 12'd2001, rgb_t'(24'h404040));
    drain();
    set_shape(MODE_FILLED, 12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 24'h0000FF);
    send_pixel(12'd4095, 12'd4095, rgb_t'(24'hFF0000));
    send_pixel(12'd0, 12'd0, rgb_t'(24'hFFFFFF));
    drain();
    set_shape(MODE_FILLED, 12'd300, 12'd300, 12'd0, 12'd0, 12'd0, 24'hC0FFEE);
    send_pixel(12'd300, 12'd300, rgb_t'(24'h000000));
    send_pixel(12'd301, 12'd301, rgb_t'(24'h000000));
    drain();
    // unused mode
    set_shape(2'd3, 12'd300, 12'd300, 12'd310, 12'd300, 12'd5, 24'hFFFFFF);
    send_pixel(12'd300, 12'd300, rgb_t'(24'h0F0F0F));
    drain();
  endtask

  task automatic test_bad_index;
    cfg_we <= 1'b1;
    cfg_index <= 3'd7;
    cfg_wdata <= 24'hFFFFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_pixel(12'd300, 12'd300, rgb_t'(24'h0F0F0F));
    drain();
  endtask

  task automatic test_random_shapes(int rounds, int per_round);
    logic [1:0] mode;
    logic [11:0] pax, pay, pbx, pby, rad, px, py;
    int span, t;
    for (int k = 0; k < rounds; k++) begin
      mode = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      pax = 12'($urandom);
      pay = 12'($urandom);
      span = ($urandom_range(9) == 0) ? 4095 : 64;
      pbx = 12'(int'(pax) + $urandom_range(2 * span) - span);
      pby = 12'(int'(pay) + $urandom_range(2 * span) - span);
      rad = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(40));
      set_shape(mode, pax, pay, pbx, pby, rad, 24'($urandom));
      for (int n = 0; n < per_round; n++) begin
        if ($urandom_range(4) == 0) begin
          px = 12'($urandom);
          py = 12'($urandom);
        end else if (mode == MODE_LINE) begin
          t = $urandom_range(100);
          px = 12'(int'(pax) + ((int'(pbx) - int'(pax)) * t) / 100 + $urandom_range(8) - 4);
          py = 12'(int'(pay) + ((int'(pby) - int'(pay)) * t) / 100 + $urandom_range(8) - 4);
        end else begin
          span = int'(rad) + 3;
          px = 12'(int'(pax) + $urandom_range(2 * span) - span);
          py = 12'(int'(pay) + $urandom_range(2 * span) - span);
        end
        send_pixel(px, py, any_rgb());
      end
      drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    in_old_red = '0;
    in_old_green = '0;
    in_old_blue = '0;
    shape_mode_q = '0;
    ax_q = '0;
    ay_q = '0;
    bx_q = '0;
    by_q = '0;
    radius_q = '0;
    color_q = '0;
    fail_count = 0;
    mismatch_count = 0;
    beats_sent = 0;
    beats_checked = 0;
    gap_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // registers at reset: zero-length line
    send_pixel(12'd0, 12'd0, rgb_t'(24'hFFFFFF));
    drain();
    gap_pct = 8;
    test_directed();
    test_bad_index();
    test_random_shapes(7, 50);
    gap_pct = 69;
    test_random_shapes(7, 50);
    gap_pct = 0;
    test_random_shapes(7, 50);
    $display("covered %0d pixel beats, %0d results checked, %0d mismatches",
             beats_sent, beats_checked, mismatch_count);
    $display("line, outline, filled and unused modes with varied shapes and gaps");
    if (fail_count == 0) begin
      $display("antialiased_shape_pixel_blend_top: match");
    end else begin
      $display("antialiased_shape_pixel_blend_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("antialiased_shape_pixel_blend_top: mismatch");
    $finish;
  end

endmodule

/* antialiased_shape_pixel_blend_top.f */
+incdir+rtl
rtl/asb_pkg.sv
rtl/asb_geom.sv
rtl/asb_div.sv
rtl/asb_isqrt.sv
rtl/asb_blend.sv
rtl/antialiased_shape_pixel_blend_top.sv
bench/tb_top.sv
